FILE: hdl/mbad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbad_pkg;

  localparam int BTN_W    = 4;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 18;
  localparam int TAKEN_W  = 7;
  localparam int EVENT_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK = 2'd2;

  localparam logic [SAMPLE_W-1:0] THR_SKIP_RST = 12'd1024;
  localparam logic [SAMPLE_W-1:0] THR_PLAY_RST = 12'd2048;
  localparam logic [SAMPLE_W-1:0] THR_LOCK_RST = 12'd3072;

  localparam logic [EVENT_W-1:0] EVENT_MAX = 8'd255;

  typedef enum logic [1:0] {
    POS_UNKNOWN = 2'd0,
    POS_SKIP    = 2'd1,
    POS_PLAY    = 2'd2,
    POS_LOCK    = 2'd3
  } pos_t;

  // Work handed from the accumulate stage to the classify stage.
  typedef struct packed {
    logic             valid;
    logic             consume;
    logic [BTN_W-1:0] button;
    logic [SUM_W-1:0] sum;
  } grp_t;

endpackage

`default_nettype wire

FILE: hdl/multilevel_button_adc_decoder_unit.sv
// Timing: the transfer of the sample completing a group loads the accumulate stage, and
// the result register is then loaded from that stage when the pipeline advances.
// Throughput: one item per cycle while item_stall is low; a full stage moves on whenever
// the result register is empty or its result is being transferred.
// Reset (rst, synchronous): thresholds return to 1024/2048/3072, all button positions
// to unknown, all pending counters and the partial group to zero.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_button_adc_decoder_unit #(
  parameter int BUTTONS = 16,
  parameter int SAMPLES = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output      logic                            item_stall,
  input  wire logic                            func,
  input  wire logic [mbad_pkg::BTN_W-1:0]      button,
  input  wire logic [mbad_pkg::SAMPLE_W-1:0]   sample,
  output      logic                            result_valid,
  input  wire logic                            result_stall,
  output      logic [mbad_pkg::BTN_W-1:0]      button_out,
  output      logic [1:0]                      position,
  output      logic                            changed,
  output      logic [mbad_pkg::EVENT_W-1:0]    pending_events,
  input  wire logic                            cfg_write,
  input  wire logic [mbad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbad_pkg::SAMPLE_W-1:0]   cfg_data
);

  localparam int SUM_W   = mbad_pkg::SUM_W;
  localparam int TAKEN_W = mbad_pkg::TAKEN_W;
  localparam int EVENT_W = mbad_pkg::EVENT_W;
  localparam int BTN_W   = mbad_pkg::BTN_W;
  localparam int BIDX_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [SUM_W-1:0]   SAMPLES_S = SUM_W'(SAMPLES);
  localparam logic [TAKEN_W-1:0] SAMPLES_T = TAKEN_W'(SAMPLES);
  localparam logic [BTN_W:0]     BUTTONS_B = (BTN_W+1)'(BUTTONS);

  // Thresholds are kept pre-multiplied by SAMPLES, so the group sum is compared
  // directly: floor(sum / SAMPLES) >= t holds exactly when sum >= t * SAMPLES.
  logic [SUM_W-1:0] thr_skip;
  logic [SUM_W-1:0] thr_play;
  logic [SUM_W-1:0] thr_lock;
  logic [SUM_W-1:0] cfg_scaled;

  logic [SUM_W-1:0]   sample_sum;
  logic [TAKEN_W-1:0] samples_taken;
  logic [BTN_W-1:0]   group_button;

  mbad_pkg::grp_t grp;
  mbad_pkg::pos_t button_position [BUTTONS];
  logic [EVENT_W-1:0] change_count [BUTTONS];

  logic               advance;
  logic               accept;
  logic               btn_ok;
  logic               restart;
  logic               done;
  logic [SUM_W-1:0]   sum_next;
  logic [TAKEN_W-1:0] taken_next;

  logic [BIDX_W-1:0]  grp_idx;
  mbad_pkg::pos_t     pos_new;
  logic               pos_chg;
  logic [EVENT_W-1:0] count_next;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  assign cfg_scaled = SUM_W'(cfg_data) * SAMPLES_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_skip <= SUM_W'(mbad_pkg::THR_SKIP_RST) * SAMPLES_S;
      thr_play <= SUM_W'(mbad_pkg::THR_PLAY_RST) * SAMPLES_S;
      thr_lock <= SUM_W'(mbad_pkg::THR_LOCK_RST) * SAMPLES_S;
    end else if (cfg_write) begin
      case (cfg_index)
        mbad_pkg::REG_SKIP: thr_skip <= cfg_scaled;
        mbad_pkg::REG_PLAY: thr_play <= cfg_scaled;
        mbad_pkg::REG_LOCK: thr_lock <= cfg_scaled;
        default: ;
      endcase
    end
  end

  // Accumulate stage.
  assign btn_ok     = {1'b0, button} < BUTTONS_B;
  assign restart    = (samples_taken == '0) || (button != group_button);
  assign sum_next   = restart ? SUM_W'(sample) : sample_sum + SUM_W'(sample);
  assign taken_next = restart ? TAKEN_W'(1) : samples_taken + TAKEN_W'(1);
  assign done       = taken_next == SAMPLES_T;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
      group_button  <= '0;
      grp.valid     <= 1'b0;
    end else begin
      if (accept && !func && btn_ok) begin
        group_button <= button;
        if (done) begin
          sample_sum    <= '0;
          samples_taken <= '0;
        end else begin
          sample_sum    <= sum_next;
          samples_taken <= taken_next;
        end
      end
      if (advance) begin
        grp.valid   <= accept && (func || (btn_ok && done));
        grp.consume <= func;
        grp.button  <= button;
        grp.sum     <= sum_next;
      end
    end
  end

  // Classify and table update stage.
  assign grp_idx = grp.button[BIDX_W-1:0];

  always_comb begin
    if (grp.sum >= thr_lock) begin
      pos_new = mbad_pkg::POS_LOCK;
    end else if (grp.sum >= thr_play) begin
      pos_new = mbad_pkg::POS_PLAY;
    end else if (grp.sum >= thr_skip) begin
      pos_new = mbad_pkg::POS_SKIP;
    end else begin
      pos_new = mbad_pkg::POS_UNKNOWN;
    end
  end

  assign pos_chg    = pos_new != button_position[grp_idx];
  assign count_next = (pos_chg && change_count[grp_idx] != mbad_pkg::EVENT_MAX) ?
                      change_count[grp_idx] + EVENT_W'(1) : change_count[grp_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        button_position[i] <= mbad_pkg::POS_UNKNOWN;
        change_count[i]    <= '0;
      end
    end else if (advance) begin
      result_valid <= grp.valid && !grp.consume;
      if (grp.valid) begin
        if (grp.consume) begin
          for (int i = 0; i < BUTTONS; i++) begin
            change_count[i] <= '0;
          end
        end else if (pos_chg) begin
          button_position[grp_idx] <= pos_new;
          change_count[grp_idx]    <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      button_out     <= grp.button;
      position       <= pos_new;
      changed        <= pos_chg;
      pending_events <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mbad_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mbad_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           item_valid,
  input wire logic                           item_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic [mbad_pkg::BTN_W-1:0]     button_out,
  input wire logic                           changed,
  input wire logic [mbad_pkg::EVENT_W-1:0]   pending_events
);

  // A result only appears after an item transfer has passed the accumulate stage and the result register.
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
    else $error("result appeared without a preceding input transfer");

  // An empty result register never holds back the input side.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while no result is waiting");

  // A change always leaves at least one pending event for that button.
  a_change_counts: assert property (@(posedge clk) disable iff (rst)
    (result_valid && changed) |-> (pending_events != '0))
    else $error("change reported with an empty event counter");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    $past(result_valid && result_stall) |-> (result_valid && $stable(button_out)))
    else $error("stalled result changed");

endmodule

bind multilevel_button_adc_decoder_unit mbad_checker u_mbad_checker (.*);

`default_nettype wire
